[rtl/core/assert_macros.svh]
// assertion macros used by the checker file egm_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is held
`define CHK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("check failed");

// clocked check that also holds during reset
`define CHK_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("reset check failed");

`endif

[rtl/core/egm_pkg.sv]
// shared types and constants of the element gradient map block
// no dependencies
package egm_pkg;

  localparam int MAX_ROWS = 32;
  localparam int IDX_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CM_DEPTH = MAX_ROWS * MAX_ROWS;
  localparam int CM_AW    = (CM_DEPTH > 1) ? $clog2(CM_DEPTH) : 1;
  localparam int Q_W      = 32;
  localparam int FL_W     = 48;
  localparam int DIF_W    = FL_W + 1;
  localparam int ACC_W    = FL_W + IDX_W + 1;
  localparam int CFG_AW   = 3;
  localparam int IN_DW    = 120;
  localparam int OUT_DW   = 80;

  localparam logic [CFG_AW-1:0] REG_JAC_00 = 3'd0;
  localparam logic [CFG_AW-1:0] REG_JAC_01 = 3'd1;
  localparam logic [CFG_AW-1:0] REG_JAC_10 = 3'd2;
  localparam logic [CFG_AW-1:0] REG_JAC_11 = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ROWS   = 3'd4;

  typedef enum logic [1:0] {MUL_DET, MUL_NX, MUL_NY} mul_sel_t;
  typedef enum logic [1:0] {TK_NONE, TK_DET, TK_NX, TK_NY} take_t;

  typedef struct packed {
    logic             latch_in;
    mul_sel_t         mul_sel;
    take_t            take;
    logic             div_start;
    logic             div_sel_y;
    logic             store_x;
    logic             store_y;
    logic             wr_map;
    logic             mac_clr;
    logic             mac_issue;
    logic [IDX_W-1:0] rd_row;
    logic [IDX_W-1:0] rd_col;
    logic             out_load;
    logic             out_last;
  } egm_cmd_t;

  typedef struct packed {
    logic             grad_ok;
    logic             det_zero;
    logic             div_done;
    logic             trigger;
    logic [IDX_W-1:0] n_last;
    logic             out_free;
  } egm_stat_t;

endpackage

[rtl/core/egm_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module egm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/egm_div.sv]
// restoring divider, one quotient bit per cycle: trunc(num * 2^16 / den), saturated
// depends on egm_pkg
module egm_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [egm_pkg::DIF_W-1:0] num,
  input  logic signed [egm_pkg::DIF_W-1:0] den,
  output logic signed [egm_pkg::Q_W-1:0]   res,
  output logic                             done
);
  import egm_pkg::*;

  localparam int DVD_W = DIF_W + 16;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [DIF_W-1:0] d_r, d_nxt, rem_r, rem_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt, q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIF_W:0]   trial;
  logic             ge;
  logic [DIF_W-1:0] num_mag, den_mag;

  assign num_mag = num[DIF_W-1] ? DIF_W'(-num) : DIF_W'(num);
  assign den_mag = den[DIF_W-1] ? DIF_W'(-den) : DIF_W'(den);
  assign trial   = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = trial >= {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    neg_nxt  = neg_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      neg_nxt  = num[DIF_W-1] ^ den[DIF_W-1];
      d_nxt    = den_mag;
      rem_nxt  = '0;
      dvd_nxt  = {num_mag, 16'd0};
      q_nxt    = '0;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? DIF_W'(trial - {1'b0, d_r}) : DIF_W'(trial);
      q_nxt   = {q_r[DVD_W-2:0], ge};
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    if (neg_r) begin
      res = (q_r > DVD_W'(33'h0_8000_0000)) ? 32'sh8000_0000 : Q_W'(-q_r);
    end else begin
      res = (q_r > DVD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : Q_W'(q_r);
    end
  end

  assign done = done_r;
endmodule

[rtl/core/egm_dp.sv]
// datapath: config registers, two multipliers, divider, coefficient and
// mapped column rams, accumulators and output register; depends on egm_pkg
module egm_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [egm_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [31:0]                  cfg_wdata,
  input  logic                         in_accept,
  input  logic                         in_tuser,
  input  logic [egm_pkg::IN_DW-1:0]    in_tdata,
  input  egm_pkg::egm_cmd_t            cmd,
  output egm_pkg::egm_stat_t           stat,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [egm_pkg::OUT_DW-1:0]   out_tdata,
  output logic                         out_tuser,
  output logic                         out_tlast
);
  import egm_pkg::*;

  logic signed [Q_W-1:0] jac00_r, jac01_r, jac10_r, jac11_r;
  logic [5:0]            rows_r;

  // input fields
  logic [4:0]            f_row, f_col;
  logic [7:0]            f_point;
  logic signed [Q_W-1:0] f_coeff, f_gx, f_gy;
  logic                  row_ok, col_ok;

  assign f_row   = in_tdata[4:0];
  assign f_col   = in_tdata[9:5];
  assign f_coeff = in_tdata[41:10];
  assign f_point = in_tdata[49:42];
  assign f_gx    = in_tdata[81:50];
  assign f_gy    = in_tdata[113:82];
  assign row_ok  = int'(f_row) < MAX_ROWS;
  assign col_ok  = int'(f_col) < MAX_ROWS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jac00_r <= 32'sd65536;
      jac01_r <= '0;
      jac10_r <= '0;
      jac11_r <= 32'sd65536;
      rows_r  <= 6'd21;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_JAC_00: jac00_r <= cfg_wdata;
        REG_JAC_01: jac01_r <= cfg_wdata;
        REG_JAC_10: jac10_r <= cfg_wdata;
        REG_JAC_11: jac11_r <= cfg_wdata;
        REG_ROWS:   rows_r  <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // last active row index
  logic [IDX_W-1:0] n_last;
  always_comb begin
    priority if (rows_r == 6'd0) begin
      n_last = '0;
    end else if (int'(rows_r) > MAX_ROWS) begin
      n_last = IDX_W'(MAX_ROWS - 1);
    end else begin
      n_last = IDX_W'(rows_r - 6'd1);
    end
  end

  logic [IDX_W-1:0]      row_r;
  logic [7:0]            point_r;
  logic signed [Q_W-1:0] gx_r, gy_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      row_r   <= IDX_W'(f_row);
      point_r <= f_point;
      gx_r    <= f_gx;
      gy_r    <= f_gy;
    end
  end

  // coefficient matrix, row major
  logic             cm_we;
  logic [CM_AW-1:0] cm_waddr, cm_raddr;
  logic [Q_W-1:0]   cm_rdata;

  assign cm_we    = in_accept && !in_tuser && row_ok && col_ok;
  assign cm_waddr = CM_AW'(CM_AW'(f_row) * CM_AW'(MAX_ROWS) + CM_AW'(f_col));
  assign cm_raddr = CM_AW'(CM_AW'(cmd.rd_row) * CM_AW'(MAX_ROWS) + CM_AW'(cmd.rd_col));

  egm_ram #(.WIDTH(Q_W), .DEPTH(CM_DEPTH)) u_cm_ram (
    .clk   (clk),
    .we    (cm_we),
    .waddr (cm_waddr),
    .wdata (in_tdata[41:10]),
    .raddr (cm_raddr),
    .rdata (cm_rdata)
  );

  // mapped column, y in the upper half
  logic signed [Q_W-1:0] mx_r, my_r;
  logic [2*Q_W-1:0]      map_wdata, map_rdata;
  logic                  det_zero;

  assign map_wdata = det_zero ? '0 : {my_r, mx_r};

  egm_ram #(.WIDTH(2*Q_W), .DEPTH(MAX_ROWS)) u_map_ram (
    .clk   (clk),
    .we    (cmd.wr_map),
    .waddr (row_r),
    .wdata (map_wdata),
    .raddr (cmd.rd_col),
    .rdata (map_rdata)
  );

  // mac pipeline valids: ram read, then product
  logic v1_r, v2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
    end
  end

  logic signed [Q_W-1:0]   ma, mb, mc, md;
  logic signed [2*Q_W-1:0] pa_r, pb_r;

  always_comb begin
    if (v1_r) begin
      ma = cm_rdata;
      mb = map_rdata[Q_W-1:0];
      mc = cm_rdata;
      md = map_rdata[2*Q_W-1:Q_W];
    end else begin
      unique case (cmd.mul_sel)
        MUL_DET: begin ma = jac00_r; mb = jac11_r; mc = jac01_r; md = jac10_r; end
        MUL_NX:  begin ma = jac11_r; mb = gx_r;    mc = jac10_r; md = gy_r;    end
        MUL_NY:  begin ma = jac00_r; mb = gy_r;    mc = jac01_r; md = gx_r;    end
        default: begin ma = jac00_r; mb = jac11_r; mc = jac01_r; md = jac10_r; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pa_r <= ma * mb;
    pb_r <= mc * md;
  end

  // floored products and their difference
  logic signed [FL_W-1:0]  fa, fb;
  logic signed [DIF_W-1:0] diff, det_r, nx_r, ny_r;

  assign fa   = pa_r[2*Q_W-1:16];
  assign fb   = pb_r[2*Q_W-1:16];
  assign diff = DIF_W'(fa) - DIF_W'(fb);

  always_ff @(posedge clk) begin
    unique case (cmd.take)
      TK_DET:  det_r <= diff;
      TK_NX:   nx_r  <= diff;
      TK_NY:   ny_r  <= diff;
      default: ;
    endcase
  end

  assign det_zero = (det_r == '0);

  logic signed [Q_W-1:0] div_res;
  logic                  div_done;

  egm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (cmd.div_sel_y ? ny_r : nx_r),
    .den   (det_r),
    .res   (div_res),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.store_x) mx_r <= div_res;
    if (cmd.store_y) my_r <= div_res;
  end

  logic signed [ACC_W-1:0] accx_r, accy_r;
  always_ff @(posedge clk) begin
    if (cmd.mac_clr) begin
      accx_r <= '0;
      accy_r <= '0;
    end else if (v2_r) begin
      accx_r <= accx_r + ACC_W'(fa);
      accy_r <= accy_r + ACC_W'(fb);
    end
  end

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi, lo;
    hi = ACC_W'(32'sh7FFF_FFFF);
    lo = ACC_W'(32'sh8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return Q_W'(v);
  endfunction

  // output register
  logic                  ov_r;
  logic [4:0]            orow_r;
  logic [7:0]            opoint_r;
  logic signed [Q_W-1:0] ogx_r, ogy_r;
  logic                  osing_r, olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
    if (cmd.out_load) begin
      orow_r   <= 5'(cmd.rd_row);
      opoint_r <= point_r;
      ogx_r    <= det_zero ? '0 : sat32(accx_r);
      ogy_r    <= det_zero ? '0 : sat32(accy_r);
      osing_r  <= det_zero;
      olast_r  <= cmd.out_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {3'd0, ogy_r, ogx_r, opoint_r, orow_r};
  assign out_tuser  = osing_r;
  assign out_tlast  = olast_r;

  assign stat.grad_ok  = row_ok;
  assign stat.det_zero = det_zero;
  assign stat.div_done = div_done;
  assign stat.trigger  = (row_r == n_last);
  assign stat.n_last   = n_last;
  assign stat.out_free = !ov_r || out_tready;
endmodule

[rtl/core/egm_ctrl.sv]
// controller: sequences the mapping of a gradient row and the result walk
// depends on egm_pkg
module egm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tuser,
  output logic                in_tready,
  output egm_pkg::egm_cmd_t   cmd,
  input  egm_pkg::egm_stat_t  stat
);
  import egm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_DIVX, S_WAITX, S_DIVY, S_WAITY,
    S_WRMAP, S_ROWST, S_ISSUE, S_D1, S_D2, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] r_r, r_nxt, j_r, j_nxt;
  logic             grad_acc;

  assign in_tready = (state_r == S_IDLE);
  assign grad_acc  = in_tvalid && in_tready && in_tuser && stat.grad_ok;

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    j_nxt     = j_r;
    cmd       = '0;
    cmd.mul_sel  = MUL_DET;
    cmd.take     = TK_NONE;
    cmd.rd_row   = r_r;
    cmd.rd_col   = j_r;
    cmd.out_last = (r_r == stat.n_last);
    unique case (state_r)
      S_IDLE: begin
        cmd.latch_in = grad_acc;
        if (grad_acc) state_nxt = S_M0;
      end
      S_M0: begin
        cmd.mul_sel = MUL_DET;
        state_nxt   = S_M1;
      end
      S_M1: begin
        cmd.mul_sel = MUL_NX;
        cmd.take    = TK_DET;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.mul_sel = MUL_NY;
        cmd.take    = TK_NX;
        state_nxt   = S_M3;
      end
      S_M3: begin
        cmd.take  = TK_NY;
        state_nxt = S_DIVX;
      end
      S_DIVX: begin
        // singular jacobian stores a zero pair without dividing
        if (stat.det_zero) begin
          state_nxt = S_WRMAP;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_WAITX;
        end
      end
      S_WAITX: begin
        if (stat.div_done) begin
          cmd.store_x = 1'b1;
          state_nxt   = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
        state_nxt     = S_WAITY;
      end
      S_WAITY: begin
        cmd.div_sel_y = 1'b1;
        if (stat.div_done) begin
          cmd.store_y = 1'b1;
          state_nxt   = S_WRMAP;
        end
      end
      S_WRMAP: begin
        cmd.wr_map = 1'b1;
        r_nxt      = '0;
        state_nxt  = stat.trigger ? S_ROWST : S_IDLE;
      end
      S_ROWST: begin
        cmd.mac_clr = 1'b1;
        j_nxt       = '0;
        state_nxt   = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.mac_issue = 1'b1;
        j_nxt         = IDX_W'(j_r + 1'b1);
        if (j_r == stat.n_last) state_nxt = S_D1;
      end
      S_D1: state_nxt = S_D2;
      S_D2: state_nxt = S_OUT;
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (r_r == stat.n_last) begin
            state_nxt = S_IDLE;
          end else begin
            r_nxt     = IDX_W'(r_r + 1'b1);
            state_nxt = S_ROWST;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      r_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      j_r     <= j_nxt;
    end
  end
endmodule

[rtl/core/element_gradient_map.sv]
// A load beat (tuser 0) writes one coefficient as it is accepted and the block stays ready for
// the next beat. A gradient beat (tuser 1) runs the two 49-bit divisions by the determinant,
// one quotient bit per cycle; a singular Jacobian skips them. When the beat is for row n-1 the
// block then walks the coefficient ram, one coefficient per cycle for both gradients at once, and
// emits n result beats; a stalled output adds its wait. Results leave through an output register.
// top level: instantiates egm_ctrl and egm_dp, depends on egm_pkg
module element_gradient_map (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [egm_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [31:0]                 cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // row[4:0], col[9:5], coeff[41:10], point[49:42], ref_grad_x[81:50], ref_grad_y[113:82]
  input  logic [egm_pkg::IN_DW-1:0]   in_tdata,
  // func
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_row[4:0], out_point[12:5], out_grad_x[44:13], out_grad_y[76:45]
  output logic [egm_pkg::OUT_DW-1:0]  out_tdata,
  // singular
  output logic                        out_tuser,
  output logic                        out_tlast
);
  import egm_pkg::*;

  egm_cmd_t  cmd;
  egm_stat_t stat;

  egm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  egm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_accept  (in_tvalid && in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );
endmodule

[rtl/core/egm_checker.sv]
// port level checks for element_gradient_map, bound to the top level
// depends on egm_pkg and assert_macros.svh
`include "assert_macros.svh"

module egm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [egm_pkg::OUT_DW-1:0] out_tdata,
  input logic                       out_tuser
);
  import egm_pkg::*;

  // a stalled result beat keeps its payload
  `CHK_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  // singular results carry zero gradients
  `CHK_ASSERT(a_sing_zero, clk, rst_n, out_tvalid && out_tuser |-> out_tdata[76:13] == '0)
  // reset empties the output register
  `CHK_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_tvalid)
endmodule

bind element_gradient_map egm_checker u_egm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[tb/testbench.sv]
// self-checking testbench for element_gradient_map: coefficient loads, gradient rows, saturation,
// singular jacobians and row counts out of range, with random stalls on both sides
// depends on egm_pkg and the element_gradient_map rtl
module testbench;
  import egm_pkg::*;

  localparam bit FUNC_LOAD = 1'b0;
  localparam bit FUNC_GRAD = 1'b1;

  typedef struct {
    bit        func;
    bit [4:0]  row;
    bit [4:0]  col;
    bit [31:0] coeff;
    bit [7:0]  point;
    bit [31:0] gx;
    bit [31:0] gy;
  } grad_item_t;

  typedef struct {
    bit [4:0]  row;
    bit [7:0]  point;
    bit [31:0] gx;
    bit [31:0] gy;
    bit        singular;
    bit        last;
  } grad_result_t;

  class map_scoreboard;
    longint jac[4];
    bit [5:0] rows;
    int signed cm[MAX_ROWS*MAX_ROWS];
    int signed map_x[MAX_ROWS];
    int signed map_y[MAX_ROWS];
    grad_result_t pending[$];
    int errors;
    int results_seen;

    function new();
      jac[0] = 65536; jac[1] = 0; jac[2] = 0; jac[3] = 65536;
      rows = 21;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, bit [31:0] v);
      case (idx)
        REG_JAC_00: jac[0] = longint'(signed'(v));
        REG_JAC_01: jac[1] = longint'(signed'(v));
        REG_JAC_10: jac[2] = longint'(signed'(v));
        REG_JAC_11: jac[3] = longint'(signed'(v));
        REG_ROWS:   rows = v[5:0];
        default: ;
      endcase
    endfunction

    function longint fmul(longint a, longint b);
      return (a * b) >>> 16;
    endfunction

    function int signed clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    // truncating q16 divide, magnitude stays below 2^48 so the shift fits
    function int signed qdiv(longint num, longint den);
      longint unsigned n, d, q;
      bit neg;
      neg = (num < 0) != (den < 0);
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = (n << 16) / d;
      if (neg) return q > 64'h80000000 ? 32'sh80000000 : int'(-longint'(q));
      return q > 64'h7fffffff ? 32'sh7fffffff : int'(q);
    endfunction

    function void note_item(grad_item_t it);
      longint det, sx, sy, c;
      int n;
      grad_result_t res;
      if (it.func == FUNC_LOAD) begin
        cm[it.row*MAX_ROWS + it.col] = signed'(it.coeff);
        return;
      end
      det = fmul(jac[0], jac[3]) - fmul(jac[1], jac[2]);
      if (det == 0) begin
        map_x[it.row] = 0;
        map_y[it.row] = 0;
      end else begin
        map_x[it.row] = qdiv(fmul(jac[3], longint'(signed'(it.gx)))
                             - fmul(jac[2], longint'(signed'(it.gy))), det);
        map_y[it.row] = qdiv(fmul(jac[0], longint'(signed'(it.gy)))
                             - fmul(jac[1], longint'(signed'(it.gx))), det);
      end
      n = rows == 0 ? 1 : (rows > MAX_ROWS ? MAX_ROWS : rows);
      if (it.row != n - 1) return;
      for (int r = 0; r < n; r++) begin
        sx = 0;
        sy = 0;
        if (det != 0) begin
          for (int j = 0; j < n; j++) begin
            c = cm[r*MAX_ROWS + j];
            sx += fmul(c, map_x[j]);
            sy += fmul(c, map_y[j]);
          end
        end
        res.row = 5'(r);
        res.point = it.point;
        res.gx = clip32(sx);
        res.gy = clip32(sy);
        res.singular = det == 0;
        res.last = r == n - 1;
        pending.push_back(res);
      end
    endfunction

    function void check_result(grad_result_t got);
      grad_result_t exp_r;
      results_seen++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat row %0d point %0d", got.row, got.point);
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r != got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp row %0d pt %0d gx %h gy %h sing %0d last %0d / got row %0d pt %0d gx %h gy %h sing %0d last %0d",
                   exp_r.row, exp_r.point, exp_r.gx, exp_r.gy, exp_r.singular, exp_r.last,
                   got.row, got.point, got.gx, got.gy, got.singular, got.last);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DW-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  element_gradient_map DUT (.*);

  always #5 clk = ~clk;

  map_scoreboard sb = new();
  grad_item_t cur;
  bit quiet = 0;
  bit hold_out = 0;
  bit cm_written[MAX_ROWS][MAX_ROWS];
  bit map_written[MAX_ROWS];
  int rand_items = 0;

  always @(posedge clk) begin
    grad_result_t got;
    if (rst_n && in_tvalid && in_tready) sb.note_item(cur);
    if (rst_n && out_tvalid && out_tready) begin
      got.row = out_tdata[4:0];
      got.point = out_tdata[12:5];
      got.gx = out_tdata[44:13];
      got.gy = out_tdata[76:45];
      got.singular = out_tuser;
      got.last = out_tlast;
      sb.check_result(got);
    end
  end

  // result sink with random stalls and a hold-off
  initial begin
    int w;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      w = quiet ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        out_tready = 0;
        repeat (w) @(negedge clk);
      end
      while (hold_out) begin
        out_tready = 0;
        @(negedge clk);
      end
      out_tready = 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, bit [31:0] v);
    cfg_we = 1;
    cfg_addr = idx;
    cfg_wdata = v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_config(bit [31:0] b00, bit [31:0] b01, bit [31:0] b10, bit [31:0] b11,
                            bit [5:0] nrows);
    write_reg(REG_JAC_00, b00);
    write_reg(REG_JAC_01, b01);
    write_reg(REG_JAC_10, b10);
    write_reg(REG_JAC_11, b11);
    write_reg(REG_ROWS, {26'd0, nrows});
  endtask

  task automatic send(grad_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    cur = it;
    in_tuser = it.func;
    in_tdata = {6'd0, it.gy, it.gx, it.point, it.coeff, it.col, it.row};
    in_tvalid = 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (it.func == FUNC_LOAD) cm_written[it.row][it.col] = 1;
    else map_written[it.row] = 1;
  endtask

  task automatic load(int r, int c, bit [31:0] v);
    grad_item_t it;
    it = '{FUNC_LOAD, 5'(r), 5'(c), v, 8'($urandom), $urandom, $urandom};
    send(it);
  endtask

  task automatic grad(int r, bit [7:0] pt, bit [31:0] gx, bit [31:0] gy);
    grad_item_t it;
    it = '{FUNC_GRAD, 5'(r), 5'($urandom), $urandom, pt, gx, gy};
    send(it);
  endtask

  // idle until every result is back and the block has had time to finish a gradient beat
  task automatic drain();
    in_tvalid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  function automatic bit [31:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 131072)) - 65536);
      default: return 32'($signed($urandom) >>> $urandom_range(0, 16));
    endcase
  endfunction

  function automatic bit [31:0] rand_jac();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h00010000;
      2: return 32'hffff0000;
      3: return rand_val();
      default: return 32'($signed($urandom) >>> $urandom_range(10, 18));
    endcase
  endfunction

  initial begin
    int n, r, sets;
    bit [5:0] nrows;
    repeat (2) @(negedge clk);
    rst_n = 1;

    // directed: one row (count zero acts as one), extremes, rows past the count
    set_config(32'h00020000, 32'h00008000, 32'hffffc000, 32'h00018000, 6'd0);
    load(0, 0, 32'h7fffffff);
    grad(0, 8'hff, 32'h7fffffff, 32'h80000000);
    load(0, 0, 32'h80000000);
    grad(0, 8'h00, 32'h80000000, 32'h7fffffff);
    grad(5, 8'h11, 32'h00010000, 32'h00010000);
    load(31, 31, 32'hffffffff);
    grad(31, 8'h22, 32'hffffffff, 32'h0);
    load(0, 0, 32'h00010000);
    grad(0, 8'h33, 32'h0, 32'h0);
    grad(0, 8'h44, 32'h00030000, 32'hfffd0000);
    drain();
    // singular jacobian
    set_config(32'h0, 32'h0, 32'h0, 32'h0, 6'd1);
    grad(0, 8'h55, 32'h12345678, 32'h9abcdef0);
    drain();
    // row count above the maximum acts as the maximum, singular so no coefficients are used
    set_config(32'h0, 32'h0, 32'h0, 32'h0, 6'd63);
    grad(31, 8'h5a, 32'h00010000, 32'hffff0000);
    drain();
    // tiny determinant saturates the quotients of large gradients
    set_config(32'h00000100, 32'h0, 32'h0, 32'h00000100, 6'd1);
    grad(0, 8'h66, 32'h7fffffff, 32'h80000000);
    grad(0, 8'h67, 32'h00000001, 32'hffffffff);
    drain();
    set_config(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 6'd2);
    load(0, 1, 32'h7fffffff); load(1, 0, 32'h80000000); load(1, 1, 32'h00010000);
    grad(0, 8'h70, 32'h7fffffff, 32'h7fffffff);
    grad(1, 8'h71, 32'h80000000, 32'h80000000);
    drain();

    for (int ph = 0; rand_items < 170 || sb.results_seen < 60; ph++) begin
      if (ph == 0) nrows = 6'd8;
      else case ($urandom_range(0, 9))
        0: nrows = 6'd0;
        1: nrows = 6'd1;
        2: nrows = 6'($urandom_range(7, 12));
        default: nrows = 6'($urandom_range(2, 6));
      endcase
      n = nrows == 0 ? 1 : (nrows > MAX_ROWS ? MAX_ROWS : nrows);
      quiet = (ph % 4) == 1;
      set_config(rand_jac(), rand_jac(), rand_jac(), rand_jac(), nrows);
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          if (!cm_written[i][j] || $urandom_range(0, 9) < 2) begin
            load(i, j, rand_val());
            rand_items++;
          end
      sets = ph == 0 ? 2 : $urandom_range(1, 3);
      for (int s = 0; s < sets; s++) begin
        // long output hold-off while the next column keeps coming
        if (ph == 0 && s == 1) begin
          fork
            begin
              hold_out = 1;
              repeat (500) @(negedge clk);
              hold_out = 0;
            end
          join_none
        end
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 9) < 2) begin
            if ($urandom_range(0, 1) || n == MAX_ROWS) begin
              load($urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_val());
            end else begin
              r = $urandom_range(n, MAX_ROWS - 1);
              grad(r, 8'($urandom), rand_val(), rand_val());
            end
            rand_items++;
          end
          grad(i, 8'($urandom), rand_val(), rand_val());
          rand_items++;
        end
        // sender waits for every result before the next column
        if (ph == 1 && s == 0) begin
          in_tvalid = 0;
          while (sb.pending.size() != 0) @(negedge clk);
        end
      end
      drain();
    end
    quiet = 0;

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      if (sb.pending.size() != 0) $display("%0d results never arrived", sb.pending.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule
